/* rtl/core/b64enc_pkg.sv */
// ============================================================================
// b64enc_pkg: shared types and constants for the Base64 stream encoder
// Holds the group descriptor that travels from the front end to the back
// end, the padding character and the alphabet lookup.
// ============================================================================
package b64enc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 24;
  localparam int unsigned SEXT_W  = 6;

  localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;   // '='
  localparam logic [1:0]        LAST_IDX = 2'd3;    // fourth character of a group

  // One encoded group as handed from the front end to the back end.
  typedef struct packed {
    logic [GROUP_W-1:0] bits;     // first byte in bits 23:16, zero filled
    logic [1:0]         pad_cnt;  // number of trailing '=' characters
    logic               last;     // group ends the message
  } b64enc_group_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [BYTE_W-1:0] b64enc_char(input logic [SEXT_W-1:0] v);
    logic [BYTE_W-1:0] ext;
    ext = {2'b00, v};
    if (v < 6'd26) begin
      b64enc_char = 8'(8'h41 + ext);
    end else if (v < 6'd52) begin
      b64enc_char = 8'(8'h61 + ext - 8'd26);
    end else if (v < 6'd62) begin
      b64enc_char = 8'(8'h30 + ext - 8'd52);
    end else if (v == 6'd62) begin
      b64enc_char = 8'h2B;
    end else begin
      b64enc_char = 8'h2F;
    end
  endfunction

endpackage

/* rtl/core/b64enc_front.sv */
// ============================================================================
// b64enc_front: byte gathering front end
// Accepts raw bytes, holds up to two of them and pushes a complete or final
// group into the queue.
// ============================================================================
module b64enc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output b64enc_pkg::b64enc_group_t     push_group_o
);
  import b64enc_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] held_q, held_d;
  logic        accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  always_comb begin
    phase_d      = phase_q;
    held_d       = held_q;
    push_o       = 1'b0;
    push_group_o = '{bits: '0, pad_cnt: 2'd0, last: in_last_i};
    if (accept) begin
      case (phase_q)
        2'd1: begin
          if (!in_last_i) begin
            held_d  = {held_q[15:8], in_byte_i};
            phase_d = 2'd2;
          end else begin
            push_o               = 1'b1;
            push_group_o.bits    = {held_q[15:8], in_byte_i, 8'h00};
            push_group_o.pad_cnt = 2'd1;
          end
        end
        2'd2: begin
          push_o               = 1'b1;
          push_group_o.bits    = {held_q, in_byte_i};
          push_group_o.pad_cnt = 2'd0;
        end
        default: begin
          // Start of a group; the unused phase code behaves the same way.
          if (!in_last_i) begin
            held_d  = {in_byte_i, 8'h00};
            phase_d = 2'd1;
          end else begin
            push_o               = 1'b1;
            push_group_o.bits    = {in_byte_i, 16'h0000};
            push_group_o.pad_cnt = 2'd2;
          end
        end
      endcase
      if (push_o) begin
        phase_d = 2'd0;
        held_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

/* rtl/core/b64enc_queue.sv */
// ============================================================================
// b64enc_queue: short group queue
// A small register queue of group descriptors between front and back end.
// ============================================================================
module b64enc_queue #(
  parameter int unsigned DEPTH = 2   // 2 to 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  b64enc_pkg::b64enc_group_t     push_group_i,
  input  logic                          pop_i,
  output logic                          full_o,
  output logic                          empty_o,
  output b64enc_pkg::b64enc_group_t     head_o
);
  import b64enc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  b64enc_group_t    entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= CNT_W'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= CNT_W'(count_q - 1'b1);
      end
    end
  end

endmodule

/* rtl/core/b64enc_back.sv */
// ============================================================================
// b64enc_back: character serializer back end
// Walks the head group one character a cycle into the output register if free.
// ============================================================================
module b64enc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  b64enc_pkg::b64enc_group_t     head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_char_o,
  output logic                          out_last_o
);
  import b64enc_pkg::*;

  logic [1:0]        idx_q;
  logic              valid_q;
  logic [7:0]        char_q;
  logic              last_q;
  logic              load;
  logic [5:0]        sextet;
  logic [2:0]        pad_sum;
  logic [7:0]        next_char;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load && (idx_q == LAST_IDX);

  always_comb begin
    case (idx_q)
      2'd0:    sextet = head_i.bits[23:18];
      2'd1:    sextet = head_i.bits[17:12];
      2'd2:    sextet = head_i.bits[11:6];
      default: sextet = head_i.bits[5:0];
    endcase
    // Positions at or past four minus the pad count carry '='.
    pad_sum   = {1'b0, idx_q} + {1'b0, head_i.pad_cnt};
    next_char = (pad_sum > 3'd3) ? PAD_CHAR : b64enc_char(sextet);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= next_char;
      last_q <= head_i.last && (idx_q == LAST_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= 2'(idx_q + 1'b1);
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

/* rtl/core/base64_stream_encoder.sv */
// ============================================================================
// base64_stream_encoder: streaming Base64 encoder, standard alphabet
// Gathers raw bytes into groups of three and emits four characters per
// group, with zero fill and '=' padding on a final partial group.
// ============================================================================
//
//   Channel   Direction  tdata (low bit up)   tlast
//   s_axis    in         data_byte[7:0]       last_byte
//   m_axis    out        char_out[7:0]        last_char
//
// The result channel carries one character per cycle while the receiver
// takes them and groups are queued; a group of three bytes gives four
// characters, which the back-end serializer emits in turn. The first
// character of a group passes from the group queue into the output register
// after the transfer that closes the group. The input is stalled only when
// the group queue is full; a waiting character holds the serializer, which reloads in the cycle it is taken.
// Reset clears the group phase, queue pointers and output valid.
//
module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2   // groups in flight, 2 to 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input byte stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
  input  logic       s_axis_tlast,    // last_byte
  // Output character stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] char_out
  output logic       m_axis_tlast     // last_char
);
  import b64enc_pkg::*;

  logic          push, pop, queue_full, queue_empty;
  b64enc_group_t push_group, head_group;

  // Front end: holds the first two bytes of a group and pushes a descriptor
  // when the third byte, or a final byte, arrives.
  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_group_o (push_group)
  );

  // Queue of whole groups, so byte intake and character output stall apart.
  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (pop),
    .full_o       (queue_full),
    .empty_o      (queue_empty),
    .head_o       (head_group)
  );

  // Back end: turns the head group into four characters, one per transfer.
  b64enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!queue_empty),
    .head_i       (head_group),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && queue_full))
    else $error("group pushed into full queue");

  // The back end never retires a group that is not there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && queue_empty))
    else $error("group popped from empty queue");

  // Only the group that ends a message may carry padding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((push_group.pad_cnt == 2'd0) || push_group.last))
    else $error("padded group without message end");

  // Every emitted character is from the alphabet or the pad character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5A) ||
                       (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h7A) ||
                       (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
                       (m_axis_tdata == 8'h2B) || (m_axis_tdata == 8'h2F) ||
                       (m_axis_tdata == PAD_CHAR)))
    else $error("character outside the alphabet");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the Base64 stream encoder
// Feeds byte messages on the input stream, predicts the characters of
// every completed group and compares each output transfer with them.
// ============================================================================
//
// The bench has three processes besides the clock. The main flow walks a
// short table of directed messages, then random messages, then waits for
// the last character and prints the verdict. The receiver stalls the output
// stream at random and checks every character transfer in order. The
// watchdog ends a run that hangs.
//
// A few directed rows carry their four characters typed in, because they can
// be read off the alphabet at a glance. All other rows and all random traffic
// are checked against the bench's own encoder model.
//
module tb_top;
  import b64enc_pkg::*;

  localparam int  CLK_HALF_NS    = 6;
  localparam int  RESET_CYCLES   = 5;
  localparam int  RANDOM_BYTES   = 430;
  localparam int  MAX_GAP        = 19;
  // After the last expected character, keep watching for a while so that a
  // stray extra transfer is still caught.
  localparam int  DRAIN_CYCLES   = 16;
  localparam int  DRAIN_LIMIT    = 20_000;
  localparam int  TIMEOUT_CYCLES = 400_000;
  localparam int  REPORT_LIMIT   = 10;
  localparam int  DIR_ROWS       = 25;

  // The character set as one vector. The first character sits in the top byte.
  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_TWO
  } grp_phase_e;

  typedef struct packed {
    logic             last;
    logic [BYTE_W-1:0] ch;
  } b64_char_t;

  // One row of the directed table. When has_chars is set, chars holds the
  // four characters that this byte must produce, first character on the left.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        has_chars;
    logic [31:0] chars;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;    // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;     // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] char_out
  logic       m_axis_tlast;            // last_char

  // Model state. It mirrors the group position and the bytes held so far.
  grp_phase_e grp_phase = PH_EMPTY;
  logic [7:0] held_hi = 8'h00;
  logic [7:0] held_lo = 8'h00;

  b64_char_t  pending_chars[$];
  dir_row_t   dir_table[DIR_ROWS];

  int  fail_cnt      = 0;
  int  bytes_sent    = 0;
  int  msgs_sent     = 0;
  int  chars_checked = 0;
  bit  quiet_stretch = 1'b0;   // both sides run without gaps while set

  always begin
    #(CLK_HALF_NS) clk_i = 1'b1;
    #(CLK_HALF_NS) clk_i = 1'b0;
  end

  base64_stream_encoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [7:0] sextet_char(input logic [5:0] idx);
    sextet_char = ALPHABET[(63 - int'(idx)) * 8 +: 8];
  endfunction

  // Encoder model. It takes one byte and returns how many characters the
  // byte releases. The count is 0 while a group is still open and 4 once a
  // group closes. A final byte closes a short group. The missing bits are
  // then filled with zeros and '=' padding takes the place of the missing
  // characters.
  function automatic int encode_byte(input logic [7:0] data, input logic last,
                                     output b64_char_t [3:0] grp);
    logic [23:0] bits;
    int          pad;
    grp = '0;
    case (grp_phase)
      PH_EMPTY: begin
        bits = {data, 16'h0000};
        pad  = 2;
      end
      PH_ONE: begin
        bits = {held_hi, data, 8'h00};
        pad  = 1;
      end
      default: begin
        bits = {held_hi, held_lo, data};
        pad  = 0;
      end
    endcase
    if (grp_phase != PH_TWO && !last) begin
      if (grp_phase == PH_EMPTY) begin
        held_hi   = data;
        grp_phase = PH_ONE;
      end else begin
        held_lo   = data;
        grp_phase = PH_TWO;
      end
      return 0;
    end
    for (int k = 0; k < 4; k++) begin
      grp[k].ch   = (k >= 4 - pad) ? PAD_CHAR : sextet_char(bits[23 - 6 * k -: 6]);
      grp[k].last = (k == 3) ? last : 1'b0;
    end
    grp_phase = PH_EMPTY;
    held_hi   = 8'h00;
    held_lo   = 8'h00;
    return 4;
  endfunction

  task automatic note_failure(input string what, input logic [8:0] exp_v,
                              input logic [8:0] act_v);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) begin
      $display("[%0t] mismatch on %s: expected %h, got %h (char #%0d)",
               $realtime, what, exp_v, act_v, chars_checked);
    end
  endtask

  function automatic int draw_gap();
    return quiet_stretch ? 0 : $urandom_range(MAX_GAP, 0);
  endfunction

  // Sends one byte and waits for its transfer. The expected characters are
  // queued right at the accepting edge. They cannot appear on the output
  // before the next edge.
  task automatic send_byte(input logic [7:0] data, input logic last,
                           input logic has_chars, input logic [31:0] chars);
    int              gap;
    int              n;
    b64_char_t [3:0] grp;
    b64_char_t       typed;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (last) msgs_sent++;
    n = encode_byte(data, last, grp);
    for (int k = 0; k < n; k++) begin
      if (has_chars) begin
        typed.ch   = chars[31 - 8 * k -: 8];
        typed.last = (k == 3) ? last : 1'b0;
        pending_chars = {pending_chars, typed};
      end else begin
        pending_chars = {pending_chars, grp[k]};
      end
    end
  endtask

  // Receiver. Before each character it draws a stall, then holds tready high
  // until a transfer happens. The sampled values are those from before the
  // edge.
  initial begin : receiver
    int        gap;
    b64_char_t exp_c;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && rst_ni)) @(posedge clk_i);
      chars_checked++;
      if (pending_chars.size() == 0) begin
        note_failure("unexpected character", 9'h000, {m_axis_tlast, m_axis_tdata});
      end else begin
        exp_c = pending_chars.pop_front();
        if (exp_c.ch !== m_axis_tdata) begin
          note_failure("char_out", {1'b0, exp_c.ch}, {1'b0, m_axis_tdata});
        end
        if (exp_c.last !== m_axis_tlast) begin
          note_failure("last_char", {8'h00, exp_c.last}, {8'h00, m_axis_tlast});
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("[%0t] run did not finish in time", $realtime);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_flow
    int       msg_len;
    int       rand_bytes;
    int       waited;
    logic [7:0] data;

    // Zeros and ones at every group position and with every padding length.
    // The classic three-byte word comes next, then the two symbol characters,
    // alternating bit patterns, and a full group followed by a short one.
    dir_table[0]  = '{8'h00, 1'b1, 1'b1, "AA=="};
    dir_table[1]  = '{8'hFF, 1'b1, 1'b1, "/w=="};
    dir_table[2]  = '{8'h00, 1'b0, 1'b0, 32'h0};
    dir_table[3]  = '{8'h00, 1'b1, 1'b1, "AAA="};
    dir_table[4]  = '{8'hFF, 1'b0, 1'b0, 32'h0};
    dir_table[5]  = '{8'hFF, 1'b1, 1'b1, "//8="};
    dir_table[6]  = '{8'h00, 1'b0, 1'b0, 32'h0};
    dir_table[7]  = '{8'h00, 1'b0, 1'b0, 32'h0};
    dir_table[8]  = '{8'h00, 1'b0, 1'b1, "AAAA"};
    dir_table[9]  = '{8'hFF, 1'b0, 1'b0, 32'h0};
    dir_table[10] = '{8'hFF, 1'b0, 1'b0, 32'h0};
    dir_table[11] = '{8'hFF, 1'b1, 1'b1, "////"};
    dir_table[12] = '{8'h4D, 1'b0, 1'b0, 32'h0};
    dir_table[13] = '{8'h61, 1'b0, 1'b0, 32'h0};
    dir_table[14] = '{8'h6E, 1'b1, 1'b0, 32'h0};
    dir_table[15] = '{8'hFB, 1'b0, 1'b0, 32'h0};
    dir_table[16] = '{8'hFF, 1'b0, 1'b0, 32'h0};
    dir_table[17] = '{8'hBF, 1'b1, 1'b0, 32'h0};
    dir_table[18] = '{8'h55, 1'b0, 1'b0, 32'h0};
    dir_table[19] = '{8'hAA, 1'b0, 1'b0, 32'h0};
    dir_table[20] = '{8'h0F, 1'b0, 1'b0, 32'h0};
    dir_table[21] = '{8'hF0, 1'b1, 1'b0, 32'h0};
    dir_table[22] = '{8'h80, 1'b1, 1'b0, 32'h0};
    dir_table[23] = '{8'h01, 1'b0, 1'b0, 32'h0};
    dir_table[24] = '{8'h7F, 1'b1, 1'b0, 32'h0};

    // Reset is asserted once, from time zero, and released on a clock edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_byte(dir_table[r].data, dir_table[r].last, dir_table[r].has_chars,
                dir_table[r].chars);
    end

    // Random messages. Most are short so that every padding case comes up
    // often. Some are long and run many full groups back to back. About one
    // message in five runs with no idling on either side.
    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      quiet_stretch = ($urandom_range(4, 0) == 0);
      msg_len = ($urandom_range(3, 0) != 0) ? $urandom_range(9, 1) : $urandom_range(40, 10);
      for (int i = 0; i < msg_len; i++) begin
        case ($urandom_range(7, 0))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom());
        endcase
        send_byte(data, (i == msg_len - 1), 1'b0, 32'h0);
        rand_bytes++;
      end
    end
    quiet_stretch = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Wait for the last character, then a short drain in which a stray extra
    // transfer would still be caught.
    waited = 0;
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $display("[%0t] %0d characters never arrived", $realtime, pending_chars.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      $display("Encoded %0d messages from %0d bytes; %0d characters compared.",
               msgs_sent, bytes_sent, chars_checked);
      $display("Traffic mixed random stalls on both streams with gap-free bursts.");
      if (fail_cnt == 0) begin
        $display("CHECK OK");
      end else begin
        $display("%0d mismatches in total", fail_cnt);
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

endmodule

/* base64_stream_encoder.f */
rtl/core/b64enc_pkg.sv
rtl/core/b64enc_front.sv
rtl/core/b64enc_queue.sv
rtl/core/b64enc_back.sv
rtl/core/base64_stream_encoder.sv
verif/tb_top.sv
